// ===== rtl/lqc_pkg.sv =====
// Shared types and constants for the linked queue with cursor.
// Used by the cell row and its cells, the top level and the testbench.
// No dependencies.
package lqc_pkg;

  // Storage geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Beat layouts
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 2;
  localparam int S_FIELDS_W = CMD_W + DATA_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = DATA_W + STAT_W + CNT_W + 1;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOENT  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADREM = 2'd3;

  // Broadcast control for the cell row: cells lo..hi-1 take their right
  // neighbor, cell hi takes the wrap slot.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] wrap;
  } chain_ctl_t;

endpackage

// ===== rtl/linked_queue_with_cursor.sv =====
// Linked queue with cursor: ordered word queue, free slots and cursor.
// Each command passes through the accept, select, update and result states in
// turn; a new command is taken only back in idle, once the result is loaded,
// and the result state holds while the output is stalled. Reset is synchronous: the
// queue is empty, the cursor null, every slot free; payload RAM is not cleared.
// Depends on lqc_pkg, lqc_chain and lqc_ram.
module linked_queue_with_cursor
  import lqc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // cmd[2:0], data[66:3], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // data_out[63:0], status[65:64],
                                          // count[72:66], is_empty[73], pad
);

  typedef enum logic [1:0] {S_IDLE, S_SEL, S_UPD, S_FIN} state_t;

  state_t            state;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] data_r;
  logic [IDX_W-1:0]  pos_r;
  logic [IDX_W-1:0]  sel_slot_r;
  logic              op_ok;
  logic [STAT_W-1:0] status_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  cur;
  logic              cur_null;

  logic [IDX_W-1:0]  pos_c;
  logic              ok_c;
  logic [STAT_W-1:0] stat_c;
  logic [IDX_W-1:0]  sel_slot;
  logic              rd_op;
  logic              upd;
  logic [CNT_W-1:0]  cnt_dec;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] word;
  chain_ctl_t        ctl;

  assign s_tready = (state == S_IDLE);
  assign rd_op    = (cmd_r == CMD_POP) || (cmd_r == CMD_HEAD) || (cmd_r == CMD_NEXT);
  assign upd      = (state == S_UPD) && op_ok;
  assign cnt_dec  = count_r - CNT_W'(1);

  // Command check and list position it touches
  always_comb begin
    pos_c  = '0;
    ok_c   = 1'b0;
    stat_c = STAT_OK;
    case (cmd_r)
      CMD_PUSH: begin
        if (count_r == CNT_W'(DEPTH)) begin
          stat_c = STAT_FULL;
        end else begin
          ok_c  = 1'b1;
          pos_c = count_r[IDX_W-1:0];
        end
      end
      CMD_POP, CMD_HEAD: begin
        if (count_r == '0) begin
          stat_c = STAT_NOENT;
        end else begin
          ok_c = 1'b1;
        end
      end
      CMD_NEXT: begin
        if (cur_null) begin
          stat_c = STAT_NOENT;
        end else begin
          ok_c  = 1'b1;
          pos_c = cur;
        end
      end
      CMD_REMOVE: begin
        if (count_r == '0 || (!cur_null && cur == '0)) begin
          stat_c = STAT_BADREM;
        end else begin
          ok_c  = 1'b1;
          // null cursor removes the tail
          pos_c = cur_null ? cnt_dec[IDX_W-1:0] : cur - IDX_W'(1);
        end
      end
      default: begin
        stat_c = STAT_NOENT;
      end
    endcase
  end

  // Row shift: victim moves to the first free position
  always_comb begin
    ctl.en   = upd && ((cmd_r == CMD_POP) || (cmd_r == CMD_REMOVE));
    ctl.lo   = pos_r;
    ctl.hi   = cnt_dec[IDX_W-1:0];
    ctl.wrap = sel_slot_r;
  end

  lqc_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sel_pos  (pos_c),
    .sel_slot (sel_slot)
  );

  lqc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_payload (
    .clk   (clk),
    .we    (upd && (cmd_r == CMD_PUSH)),
    .waddr (sel_slot_r),
    .wdata (data_r),
    .re    (upd && rd_op),
    .raddr (sel_slot_r),
    .rdata (ram_rdata)
  );

  assign word = (op_ok && rd_op) ? ram_rdata : '0;

  // Sequencer, queue bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count_r  <= '0;
      cur      <= '0;
      cur_null <= 1'b1;
      m_tvalid <= 1'b0;
      op_ok    <= 1'b0;
    end else begin
      // result taken; a new one loaded in S_FIN overrides
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r  <= s_tdata[CMD_W-1:0];
            data_r <= s_tdata[CMD_W +: DATA_W];
            state  <= S_SEL;
          end
        end
        S_SEL: begin
          pos_r      <= pos_c;
          sel_slot_r <= sel_slot;
          op_ok      <= ok_c;
          status_r   <= stat_c;
          state      <= S_UPD;
        end
        S_UPD: begin
          if (op_ok) begin
            case (cmd_r)
              CMD_PUSH: begin
                count_r <= count_r + CNT_W'(1);
              end
              CMD_POP: begin
                count_r <= cnt_dec;
                if (!cur_null) begin
                  if (cur == '0) begin
                    // cursor at head moves to successor
                    if (count_r == CNT_W'(1)) begin
                      cur_null <= 1'b1;
                    end
                  end else begin
                    cur <= cur - IDX_W'(1);
                  end
                end
              end
              CMD_HEAD: begin
                if (count_r == CNT_W'(1)) begin
                  cur      <= '0;
                  cur_null <= 1'b1;
                end else begin
                  cur      <= IDX_W'(1);
                  cur_null <= 1'b0;
                end
              end
              CMD_NEXT: begin
                if (CNT_W'(cur) + CNT_W'(1) == count_r) begin
                  cur_null <= 1'b1;
                end else begin
                  cur <= cur + IDX_W'(1);
                end
              end
              CMD_REMOVE: begin
                count_r <= cnt_dec;
                if (!cur_null) begin
                  cur <= cur - IDX_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_TDATA_W'({(count_r == '0), count_r, status_r, word});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lqc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the payload words; no dependencies.
module lqc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lqc_cell.sv =====
// One cell of the ordering row: holds the RAM slot of one list position.
// Depends on lqc_pkg.
module lqc_cell
  import lqc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,      // fixed position of this cell
  input  chain_ctl_t       ctl,
  input  logic [IDX_W-1:0] right,    // slot held by the right neighbor
  input  logic [IDX_W-1:0] sel_pos,
  output logic [IDX_W-1:0] slot,
  output logic [IDX_W-1:0] sel_out
);

  logic in_shift;
  logic at_wrap;

  assign in_shift = ctl.en && (idx >= ctl.lo) && (idx < ctl.hi);
  assign at_wrap  = ctl.en && (idx == ctl.hi);

  // Reset leaves position i holding slot i, i.e. the whole row free
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= idx;
    end else if (in_shift) begin
      slot <= right;
    end else if (at_wrap) begin
      slot <= ctl.wrap;
    end
  end

  assign sel_out = (idx == sel_pos) ? slot : '0;

endmodule

// ===== rtl/lqc_chain.sv =====
// Row of DEPTH ordering cells plus the OR-reduce that picks one position.
// Positions below the count are the queue in order, the rest are free slots.
// Depends on lqc_pkg and lqc_cell.
module lqc_chain
  import lqc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  chain_ctl_t       ctl,
  input  logic [IDX_W-1:0] sel_pos,
  output logic [IDX_W-1:0] sel_slot
);

  logic [IDX_W-1:0] slots     [DEPTH];
  logic [IDX_W-1:0] sel_parts [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [IDX_W-1:0] right;
    if (i < DEPTH - 1) begin : g_mid
      assign right = slots[i+1];
    end else begin : g_end
      // last cell never shifts in from the right
      assign right = slots[i];
    end
    lqc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .ctl     (ctl),
      .right   (right),
      .sel_pos (sel_pos),
      .slot    (slots[i]),
      .sel_out (sel_parts[i])
    );
  end

  // Only the addressed cell contributes
  always_comb begin
    sel_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_slot = sel_slot | sel_parts[i];
    end
  end

endmodule

// ===== tb/linked_queue_with_cursor_tb.sv =====
// Testbench for linked_queue_with_cursor: streams push, pop and cursor commands,
// then checks every result beat against an in-bench model of the linked list.
// Depends on lqc_pkg and the linked_queue_with_cursor RTL.
`timescale 1ns / 100ps

module linked_queue_with_cursor_tb;
  import lqc_pkg::*;

  localparam int          RANDOM_CMDS = 1000;
  localparam int          DRAIN_WAIT  = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          MAX_REPORTS = 10;

  typedef logic [IDX_W:0] ptr_t;
  localparam ptr_t NIL = ptr_t'(DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              empty;
  } queue_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    bit                drain_first;
  } queue_cmd_t;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_WALK, SEG_MIXED} seg_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  linked_queue_with_cursor uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the list: payload, links, pointers and count
  logic [DATA_W-1:0] q_payload [DEPTH];
  ptr_t              q_link    [DEPTH];
  ptr_t              q_head, q_tail, q_cursor, q_free;
  logic [CNT_W-1:0]  q_count;

  queue_cmd_t    pending_cmds [$];
  queue_result_t expected_results [$];
  queue_cmd_t    drive_cmd;
  int            total_cmds;
  int            cmds_accepted = 0;
  int            mismatches = 0;
  int unsigned   cycle_count = 0;

  function automatic void clear_queue_model();
    for (int i = 0; i < DEPTH; i++) begin
      q_link[i] = ptr_t'(i + 1);
    end
    q_head   = NIL;
    q_tail   = NIL;
    q_cursor = NIL;
    q_free   = '0;
    q_count  = '0;
  endfunction

  function automatic void free_slot(ptr_t p);
    q_link[p[IDX_W-1:0]] = q_free;
    q_free    = p;
  endfunction

  // Entry whose link points at target, walking from the head
  function automatic ptr_t pred_of(ptr_t target);
    ptr_t p;
    p = q_head;
    if (p == target) return NIL;
    for (int i = 0; i < DEPTH && p != NIL; i++) begin
      if (q_link[p[IDX_W-1:0]] == target) return p;
      p = q_link[p[IDX_W-1:0]];
    end
    return NIL;
  endfunction

  function automatic queue_result_t apply_queue_cmd(logic [CMD_W-1:0] cmd,
                                                    logic [DATA_W-1:0] word);
    queue_result_t r;
    ptr_t          p, victim, prev;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        if (q_count >= DEPTH || q_free == NIL) begin
          r.status = STAT_FULL;
        end else begin
          p = q_free;
          q_free = q_link[p[IDX_W-1:0]];
          q_payload[p[IDX_W-1:0]] = word;
          q_link[p[IDX_W-1:0]] = NIL;
          if (q_tail != NIL) q_link[q_tail[IDX_W-1:0]] = p;
          else q_head = p;
          q_tail = p;
          q_count++;
        end
      end
      CMD_POP: begin
        if (q_head == NIL) begin
          r.status = STAT_NOENT;
        end else begin
          p = q_head;
          r.word = q_payload[p[IDX_W-1:0]];
          // cursor on the popped entry slides to its successor
          if (q_cursor == p) q_cursor = q_link[p[IDX_W-1:0]];
          q_head = q_link[p[IDX_W-1:0]];
          if (q_head == NIL) q_tail = NIL;
          free_slot(p);
          q_count--;
        end
      end
      CMD_HEAD, CMD_NEXT: begin
        if (cmd == CMD_HEAD) q_cursor = q_head;
        if (q_cursor != NIL) begin
          r.word = q_payload[q_cursor[IDX_W-1:0]];
          q_cursor = q_link[q_cursor[IDX_W-1:0]];
        end else begin
          r.status = STAT_NOENT;
        end
      end
      CMD_REMOVE: begin
        // a null cursor makes the tail the victim
        victim = NIL;
        if (q_head != NIL && q_cursor != q_head) victim = pred_of(q_cursor);
        if (victim == NIL) begin
          r.status = STAT_BADREM;
        end else begin
          prev = pred_of(victim);
          if (prev == NIL) q_head = q_link[victim[IDX_W-1:0]];
          else q_link[prev[IDX_W-1:0]] = q_cursor;
          if (victim == q_tail) q_tail = prev;
          free_slot(victim);
          q_count--;
        end
      end
      default: r.status = STAT_NOENT;
    endcase
    r.count = q_count;
    r.empty = (q_head == NIL);
    return r;
  endfunction

  // Idle rates per third of the run
  function automatic int idle_phase();
    return (cmds_accepted * 3) / total_cmds;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_phase())
      0:       return 18;
      1:       return 87;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (idle_phase())
      0:       return 87;
      1:       return 18;
      default: return 0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                                  bit drain_first);
    queue_cmd_t c;
    c.cmd = cmd;
    c.data = data;
    c.drain_first = drain_first;
    pending_cmds.push_back(c);
  endfunction

  // Command mix per segment kind
  function automatic logic [CMD_W-1:0] pick_cmd(seg_kind_t kind, int idx);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      SEG_FILL:
        return (r < 88) ? CMD_PUSH : (r < 94) ? CMD_POP : CMD_NEXT;
      SEG_DRAIN:
        return (r < 80) ? CMD_POP : (r < 88) ? CMD_PUSH : (r < 94) ? CMD_REMOVE : CMD_HEAD;
      SEG_WALK: begin
        if (idx == 0) return CMD_HEAD;
        return (r < 50) ? CMD_NEXT : (r < 80) ? CMD_REMOVE : (r < 88) ? CMD_HEAD :
               (r < 94) ? CMD_PUSH : CMD_POP;
      end
      default: begin
        if (r >= 94) return CMD_REMOVE + CMD_W'($urandom_range(1, 3));
        return (r < 30) ? CMD_PUSH : (r < 55) ? CMD_POP : (r < 67) ? CMD_HEAD :
               (r < 82) ? CMD_NEXT : CMD_REMOVE;
      end
    endcase
  endfunction

  // Stimulus, reset and end of run
  initial begin
    seg_kind_t kind;
    int        seg_len;
    bit        first_seg;

    // empty queue corners and unused codes
    add_cmd(CMD_POP, rand_word(), 1'b0);
    add_cmd(CMD_NEXT, rand_word(), 1'b0);
    add_cmd(CMD_HEAD, rand_word(), 1'b0);
    add_cmd(CMD_REMOVE, rand_word(), 1'b0);
    for (int k = 1; k <= 3; k++) add_cmd(CMD_REMOVE + CMD_W'(k), rand_word(), 1'b0);
    // data extremes
    add_cmd(CMD_PUSH, '0, 1'b0);
    add_cmd(CMD_PUSH, '1, 1'b0);
    add_cmd(CMD_PUSH, {DATA_W/2{2'b10}}, 1'b0);
    add_cmd(CMD_PUSH, {DATA_W/2{2'b01}}, 1'b0);
    // cursor on the second entry: removal takes the head
    add_cmd(CMD_HEAD, rand_word(), 1'b0);
    add_cmd(CMD_REMOVE, rand_word(), 1'b0);
    // cursor now at the head: invalid removal
    add_cmd(CMD_REMOVE, rand_word(), 1'b0);
    add_cmd(CMD_NEXT, rand_word(), 1'b0);
    add_cmd(CMD_POP, rand_word(), 1'b0);
    // pop of the entry under the cursor
    add_cmd(CMD_POP, rand_word(), 1'b0);
    // cursor runs off the end, push keeps it null, removal takes the tail
    add_cmd(CMD_NEXT, rand_word(), 1'b0);
    add_cmd(CMD_PUSH, rand_word(), 1'b0);
    add_cmd(CMD_REMOVE, rand_word(), 1'b0);
    add_cmd(CMD_NEXT, rand_word(), 1'b0);

    // random segments: fill, drain, walk the cursor, or a mix
    total_cmds = pending_cmds.size() + RANDOM_CMDS;
    first_seg = 1'b1;
    while (pending_cmds.size() < total_cmds) begin
      kind = seg_kind_t'($urandom_range(0, 3));
      seg_len = (kind == SEG_FILL) ? $urandom_range(40, 90) : $urandom_range(10, 50);
      for (int i = 0; i < seg_len; i++) begin
        add_cmd(pick_cmd(kind, i), rand_word(),
                i == 0 && (first_seg || $urandom_range(0, 5) == 0));
      end
      first_seg = 1'b0;
    end
    total_cmds = pending_cmds.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("linked_queue_with_cursor_tb: done, clean");
    end else begin
      $display("linked_queue_with_cursor_tb: done, errors");
    end
    $finish;
  end

  // Driver: presents command beats, predicts on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      clear_queue_model();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_queue_cmd(drive_cmd.cmd, drive_cmd.data));
        cmds_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 &&
            !(pending_cmds[0].drain_first && expected_results.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle_pct()) begin
          drive_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= S_TDATA_W'({drive_cmd.data, drive_cmd.cmd});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats in order, stalls at random
  always @(posedge clk) begin
    queue_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.word   = m_tdata[DATA_W-1:0];
        got.status = m_tdata[DATA_W +: STAT_W];
        got.count  = m_tdata[DATA_W+STAT_W +: CNT_W];
        got.empty  = m_tdata[DATA_W+STAT_W+CNT_W];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected: data %h status %0d",
                     $realtime, got.word, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.word !== want.word || got.status !== want.status ||
              got.count !== want.count || got.empty !== want.empty) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: mismatch: exp data %h status %0d count %0d empty %0d,",
                        " got data %h status %0d count %0d empty %0d"}, $realtime,
                       want.word, want.status, want.count, want.empty,
                       got.word, got.status, got.count, got.empty);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("linked_queue_with_cursor_tb: done, errors");
      $finish;
    end
  end

endmodule
